/* hw/rtl/pfg_pkg.sv */
// Shared constants and fixed-point helpers for the particle force generator.
// No dependencies.
package pfg_pkg;

  localparam int SQRT_STAGES = 8;
  localparam int SQRT_STEPS  = 32 / SQRT_STAGES;
  localparam int DIV_STAGES  = 4;
  localparam int DIV_STEPS   = 32 / DIV_STAGES;

  localparam logic [2:0] MODE_GRAVITY  = 3'd0;
  localparam logic [2:0] MODE_DRAG     = 3'd1;
  localparam logic [2:0] MODE_SPRING   = 3'd2;
  localparam logic [2:0] MODE_ANCHORED = 3'd3;
  localparam logic [2:0] MODE_BUNGEE   = 3'd4;

  localparam logic [2:0] REG_FORCE_MODE      = 3'd0;
  localparam logic [2:0] REG_SPRING_CONSTANT = 3'd1;
  localparam logic [2:0] REG_REST_LENGTH     = 3'd2;
  localparam logic [2:0] REG_DRAG_LINEAR     = 3'd3;
  localparam logic [2:0] REG_DRAG_QUADRATIC  = 3'd4;
  localparam logic [2:0] REG_GRAVITY_X       = 3'd5;
  localparam logic [2:0] REG_GRAVITY_Y       = 3'd6;
  localparam logic [2:0] REG_GRAVITY_Z       = 3'd7;

  localparam logic signed [31:0] I32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'(I32_MAX)) return I32_MAX;
    if (v < 66'(I32_MIN)) return I32_MIN;
    return v[31:0];
  endfunction

  // Q16.16 product scale: divide by 65536 toward zero, then saturate.
  function automatic logic signed [31:0] mulq(input logic signed [63:0] p);
    logic signed [65:0] q;
    q = 66'($signed(p[63:16]));
    if (p[63] && (p[15:0] != 16'd0)) q = q + 66'sd1;
    return sat32(q);
  endfunction

endpackage

/* hw/rtl/pfg_if.sv */
// Valid/ready channels for particle items and force results.
// Depends on nothing.
interface pfg_item_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [31:0] ref_x, ref_y, ref_z;
  logic signed [31:0] vel_x, vel_y, vel_z;
  logic        [30:0] mass;
  logic               finite_mass;
  modport source (output valid, pos_x, pos_y, pos_z, ref_x, ref_y, ref_z,
                  vel_x, vel_y, vel_z, mass, finite_mass, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, ref_x, ref_y, ref_z,
                  vel_x, vel_y, vel_z, mass, finite_mass, output ready);
endinterface

interface pfg_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_x, force_y, force_z;
  logic               applied;
  modport source (output valid, force_x, force_y, force_z, applied, input ready);
  modport sink   (input valid, force_x, force_y, force_z, applied, output ready);
endinterface

/* hw/rtl/pfg_isqrt.sv */
// Pipelined 64-bit integer square root, SQRT_STEPS result bits per stage.
// Depends on pfg_pkg.
module pfg_isqrt (
  input  logic        clk,
  input  logic        adv,
  input  logic [63:0] value,
  output logic [31:0] root
);

  logic [63:0] n_s [pfg_pkg::SQRT_STAGES];
  logic [63:0] r_s [pfg_pkg::SQRT_STAGES];

  for (genvar g = 0; g < pfg_pkg::SQRT_STAGES; g++) begin : g_stage
    logic [63:0] n_in, r_in, n_out, r_out;
    if (g == 0) begin : g_first
      assign n_in = value;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = n_s[g-1];
      assign r_in = r_s[g-1];
    end
    always_comb begin
      logic [63:0] one_bit;
      logic [63:0] trial;
      n_out = n_in;
      r_out = r_in;
      one_bit = '0;
      trial = '0;
      for (int k = 0; k < pfg_pkg::SQRT_STEPS; k++) begin
        one_bit = 64'd1 << (62 - 2 * (g * pfg_pkg::SQRT_STEPS + k));
        trial = r_out + one_bit;
        if (n_out >= trial) begin
          n_out = n_out - trial;
          r_out = (r_out >> 1) + one_bit;
        end else begin
          r_out = r_out >> 1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        n_s[g] <= n_out;
        r_s[g] <= r_out;
      end
    end
  end

  assign root = r_s[pfg_pkg::SQRT_STAGES-1][31:0];

endmodule

/* hw/rtl/pfg_div.sv */
// Pipelined restoring divider: 63-bit numerator by 32-bit divisor, 32-bit
// quotient, for numerators below divisor * 2^32. Depends on pfg_pkg.
module pfg_div (
  input  logic        clk,
  input  logic        adv,
  input  logic [62:0] num,
  input  logic [31:0] den,
  output logic [31:0] quo
);

  logic [31:0] r_s [pfg_pkg::DIV_STAGES];
  logic [31:0] n_s [pfg_pkg::DIV_STAGES];
  logic [31:0] q_s [pfg_pkg::DIV_STAGES];
  logic [31:0] d_s [pfg_pkg::DIV_STAGES];

  for (genvar g = 0; g < pfg_pkg::DIV_STAGES; g++) begin : g_stage
    logic [31:0] r_in, n_in, q_in, d_in, r_out, n_out, q_out;
    if (g == 0) begin : g_first
      assign r_in = {1'b0, num[62:32]};
      assign n_in = num[31:0];
      assign q_in = '0;
      assign d_in = den;
    end else begin : g_next
      assign r_in = r_s[g-1];
      assign n_in = n_s[g-1];
      assign q_in = q_s[g-1];
      assign d_in = d_s[g-1];
    end
    always_comb begin
      logic [32:0] part;
      logic        ge;
      r_out = r_in;
      n_out = n_in;
      q_out = q_in;
      part = '0;
      ge = 1'b0;
      for (int k = 0; k < pfg_pkg::DIV_STEPS; k++) begin
        part = {r_out, n_out[31]};
        n_out = {n_out[30:0], 1'b0};
        ge = (part >= {1'b0, d_in});
        if (ge) part = part - {1'b0, d_in};
        r_out = part[31:0];
        q_out = {q_out[30:0], ge};
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        r_s[g] <= r_out;
        n_s[g] <= n_out;
        q_s[g] <= q_out;
        d_s[g] <= d_in;
      end
    end
  end

  assign quo = q_s[pfg_pkg::DIV_STAGES-1];

endmodule

/* hw/rtl/particle_force_generator_unit.sv */
// Top level of the particle force generator: configuration registers, force
// pipeline, output register. Depends on pfg_pkg, pfg_if, pfg_isqrt, pfg_div.
//
// One particle per clock enters and one force vector leaves per clock while
// results are taken. The pipeline contains the pipelined square root of
// |d|^2 and the pipelined divisions of M*d_i by the length. The whole
// pipeline holds when a valid result is not taken; item.ready is low only
// then. Write the configuration only while no item is in flight.
module particle_force_generator_unit (
  input  logic                clk,
  input  logic                rst,
  pfg_item_if.sink            item,
  pfg_result_if.source        result,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int SL = pfg_pkg::SQRT_STAGES;
  localparam int DL = pfg_pkg::DIV_STAGES;

  typedef struct packed {
    logic [2:0][31:0] d;
    logic [2:0][31:0] gf;
    logic             finite;
  } side_a_t;

  typedef struct packed {
    logic [2:0]       sign;
    logic [2:0]       ovf;
    logic             len_zero;
    logic             skip;
    logic [2:0][31:0] gf;
    logic             finite;
  } side_b_t;

  logic [2:0]         force_mode;
  logic signed [31:0] spring_constant;
  logic [30:0]        rest_length;
  logic signed [31:0] drag_linear, drag_quadratic;
  logic signed [31:0] gravity_x, gravity_y, gravity_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      force_mode <= '0;
      spring_constant <= '0;
      rest_length <= '0;
      drag_linear <= '0;
      drag_quadratic <= '0;
      gravity_x <= '0;
      gravity_y <= '0;
      gravity_z <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pfg_pkg::REG_FORCE_MODE:      force_mode <= cfg_data[2:0];
        pfg_pkg::REG_SPRING_CONSTANT: spring_constant <= cfg_data;
        pfg_pkg::REG_REST_LENGTH:     rest_length <= cfg_data[30:0];
        pfg_pkg::REG_DRAG_LINEAR:     drag_linear <= cfg_data;
        pfg_pkg::REG_DRAG_QUADRATIC:  drag_quadratic <= cfg_data;
        pfg_pkg::REG_GRAVITY_X:       gravity_x <= cfg_data;
        pfg_pkg::REG_GRAVITY_Y:       gravity_y <= cfg_data;
        pfg_pkg::REG_GRAVITY_Z:       gravity_z <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv = !result.valid || result.ready;
  assign item.ready = adv;

  // valid bits
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9;
  logic vs [SL];
  logic vd [DL];

  // stage 1: offset or velocity
  logic [2:0][31:0] d1;
  logic [30:0]      mass1;
  logic             fin1;
  logic [2:0][31:0] d1_next;
  logic signed [31:0] pv [3], rv [3], vv [3];

  assign pv[0] = item.pos_x; assign pv[1] = item.pos_y; assign pv[2] = item.pos_z;
  assign rv[0] = item.ref_x; assign rv[1] = item.ref_y; assign rv[2] = item.ref_z;
  assign vv[0] = item.vel_x; assign vv[1] = item.vel_y; assign vv[2] = item.vel_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (force_mode == pfg_pkg::MODE_DRAG) d1_next[i] = vv[i];
      else d1_next[i] = pfg_pkg::sat32(66'(pv[i]) - 66'(rv[i]));
    end
  end

  // stage 2: squares and gravity products
  logic [2:0][63:0] sq2, gp2;
  logic [2:0][31:0] d2;
  logic             fin2;
  logic signed [31:0] grav [3];
  assign grav[0] = gravity_x; assign grav[1] = gravity_y; assign grav[2] = gravity_z;

  // stage 3: sum of squares, scaled gravity
  logic [63:0]      sum3;
  logic [2:0][31:0] gf3, d3;
  logic             fin3;

  // square root span
  side_a_t sa [SL];
  logic [31:0] len_s;

  // stage 4: first products
  logic signed [63:0] p1_4, p2_4;
  logic [31:0] len4;
  logic        skip4;
  side_a_t     a4;
  logic [30:0] ls;
  logic signed [31:0] rdiff, adiff, op_a, op_b;

  always_comb begin
    ls = (len_s > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : len_s[30:0];
    rdiff = $signed({1'b0, rest_length}) - $signed({1'b0, ls});
    adiff = rdiff[31] ? -rdiff : rdiff;
    op_a = spring_constant;
    op_b = rdiff;
    case (force_mode)
      pfg_pkg::MODE_DRAG: begin
        op_a = drag_linear;
        op_b = $signed({1'b0, ls});
      end
      pfg_pkg::MODE_SPRING: op_b = adiff;
      default: ;
    endcase
  end

  // stages 5 to 7: scale, quadratic term, magnitude
  logic signed [31:0] t1_5, t2_5, t1_6;
  logic signed [63:0] p3_6;
  logic signed [32:0] m7, m7_next;
  logic [31:0] len5, len6, len7;
  logic        skip5, skip6, skip7;
  side_a_t     a5, a6, a7;
  logic signed [31:0] drag_sum;

  always_comb begin
    drag_sum = pfg_pkg::sat32(66'(t1_6) + 66'(pfg_pkg::mulq(p3_6)));
    case (force_mode)
      pfg_pkg::MODE_DRAG:   m7_next = -33'(drag_sum);
      pfg_pkg::MODE_SPRING: m7_next = -33'(t1_6);
      default:              m7_next = 33'(t1_6);
    endcase
  end

  // stage 8: M * d_i
  logic [2:0][63:0] pm8;
  logic [31:0]      len8;
  logic             skip8, fin8;
  logic [2:0][31:0] gf8;

  // stage 9: sign, magnitude, overflow check
  logic [2:0][62:0] num9;
  logic [31:0]      len9;
  side_b_t          b9;
  side_b_t          b9_next;
  logic [2:0][62:0] num9_next;

  always_comb begin
    b9_next.len_zero = (len8 == 32'd0);
    b9_next.skip = skip8;
    b9_next.gf = gf8;
    b9_next.finite = fin8;
    for (int i = 0; i < 3; i++) begin
      b9_next.sign[i] = pm8[i][63];
      num9_next[i] = pm8[i][63] ? 63'(-$signed(pm8[i])) : pm8[i][62:0];
      b9_next.ovf[i] = {1'b0, num9_next[i]} >= {len8, 32'd0};
    end
  end

  side_b_t sb [DL];
  logic [2:0][31:0] quo;

  for (genvar i = 0; i < 3; i++) begin : g_div
    pfg_div u_div (
      .clk (clk),
      .adv (adv),
      .num (num9[i]),
      .den (len9),
      .quo (quo[i])
    );
  end

  pfg_isqrt u_sqrt (
    .clk   (clk),
    .adv   (adv),
    .value (sum3),
    .root  (len_s)
  );

  function automatic logic signed [31:0] signed_quo(input logic sign, input logic ovf,
                                                    input logic [31:0] q);
    if (ovf) return sign ? pfg_pkg::I32_MIN : pfg_pkg::I32_MAX;
    if (!sign) return q[31] ? pfg_pkg::I32_MAX : $signed(q);
    return (q > 32'h8000_0000) ? pfg_pkg::I32_MIN : $signed(-q);
  endfunction

  logic [2:0][31:0] f_next;
  logic             app_next;
  side_b_t          bl;
  assign bl = sb[DL-1];

  always_comb begin
    f_next = '0;
    app_next = 1'b0;
    case (force_mode)
      pfg_pkg::MODE_GRAVITY: begin
        app_next = bl.finite;
        if (bl.finite) f_next = bl.gf;
      end
      pfg_pkg::MODE_DRAG, pfg_pkg::MODE_SPRING, pfg_pkg::MODE_ANCHORED,
      pfg_pkg::MODE_BUNGEE: begin
        if (!(force_mode == pfg_pkg::MODE_BUNGEE && bl.skip)) begin
          app_next = 1'b1;
          if (!bl.len_zero) begin
            for (int i = 0; i < 3; i++) f_next[i] = signed_quo(bl.sign[i], bl.ovf[i], quo[i]);
          end
        end
      end
      default: ;
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      d1 <= d1_next;
      mass1 <= item.mass;
      fin1 <= item.finite_mass;

      for (int i = 0; i < 3; i++) begin
        sq2[i] <= 64'($signed(d1[i])) * 64'($signed(d1[i]));
        gp2[i] <= 64'(grav[i]) * 64'($signed({1'b0, mass1}));
      end
      d2 <= d1;
      fin2 <= fin1;

      sum3 <= sq2[0] + sq2[1] + sq2[2];
      for (int i = 0; i < 3; i++) gf3[i] <= pfg_pkg::mulq(gp2[i]);
      d3 <= d2;
      fin3 <= fin2;

      sa[0] <= '{d: d3, gf: gf3, finite: fin3};
      for (int j = 1; j < SL; j++) sa[j] <= sa[j-1];

      p1_4 <= 64'(op_a) * 64'(op_b);
      p2_4 <= 64'($signed({1'b0, ls})) * 64'($signed({1'b0, ls}));
      len4 <= len_s;
      skip4 <= len_s <= {1'b0, rest_length};
      a4 <= sa[SL-1];

      t1_5 <= pfg_pkg::mulq(p1_4);
      t2_5 <= pfg_pkg::mulq(p2_4);
      len5 <= len4; skip5 <= skip4; a5 <= a4;

      t1_6 <= t1_5;
      p3_6 <= 64'(drag_quadratic) * 64'(t2_5);
      len6 <= len5; skip6 <= skip5; a6 <= a5;

      m7 <= m7_next;
      len7 <= len6; skip7 <= skip6; a7 <= a6;

      for (int i = 0; i < 3; i++) pm8[i] <= 64'(m7) * 64'($signed(a7.d[i]));
      len8 <= len7; skip8 <= skip7; fin8 <= a7.finite; gf8 <= a7.gf;

      num9 <= num9_next;
      len9 <= len8;
      b9 <= b9_next;

      sb[0] <= b9;
      for (int j = 1; j < DL; j++) sb[j] <= sb[j-1];

      result.force_x <= f_next[0];
      result.force_y <= f_next[1];
      result.force_z <= f_next[2];
      result.applied <= app_next;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9} <= '0;
      for (int j = 0; j < SL; j++) vs[j] <= 1'b0;
      for (int j = 0; j < DL; j++) vd[j] <= 1'b0;
      result.valid <= 1'b0;
    end else if (adv) begin
      v1 <= item.valid;
      v2 <= v1;
      v3 <= v2;
      vs[0] <= v3;
      for (int j = 1; j < SL; j++) vs[j] <= vs[j-1];
      v4 <= vs[SL-1];
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
      v9 <= v8;
      vd[0] <= v9;
      for (int j = 1; j < DL; j++) vd[j] <= vd[j-1];
      result.valid <= vd[DL-1];
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.applied |->
      result.force_x == 32'sd0 && result.force_y == 32'sd0 && result.force_z == 32'sd0)
    else $error("skipped force carries a nonzero vector");

  a_unused_mode: assert property (@(posedge clk) disable iff (rst)
    result.valid && force_mode > pfg_pkg::MODE_BUNGEE |-> !result.applied)
    else $error("unused mode applied a force");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> result.valid && !result.ready)
    else $error("input held off without a blocked result");

endmodule

/* dv/particle_force_generator_checker.sv */
// Force checker for particle_force_generator_unit: predicts each force vector
// from the accepted particle and the register writes, and compares results.
// Depends on pfg_pkg and pfg_if.
`timescale 1ns / 1ps

module particle_force_generator_checker (
  input  logic        clk,
  input  logic        rst,
  pfg_item_if         item,
  pfg_result_if       result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          forces_due,
  output int          forces_seen
);

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic               applied;
  } force_t;

  force_t     force_q[$];
  logic [2:0] mode;
  longint     k, rest, k1, k2, gx, gy, gz;

  function automatic longint clip(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return clip((a * b) / 65536);
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned norm3(longint d[3]);
    longint unsigned s;
    s = 0;
    for (int i = 0; i < 3; i++) s += longint'(d[i] * d[i]);
    return root64(s);
  endfunction

  function automatic force_t particle_force();
    force_t          f;
    longint          d[3], v[3], m, ls;
    longint unsigned len;
    logic            use_dir;
    f = '0;
    f.applied = 1'b1;
    use_dir = 1'b1;
    m = 0;
    d[0] = clip(longint'(item.pos_x) - longint'(item.ref_x));
    d[1] = clip(longint'(item.pos_y) - longint'(item.ref_y));
    d[2] = clip(longint'(item.pos_z) - longint'(item.ref_z));
    case (mode)
      pfg_pkg::MODE_GRAVITY: begin
        use_dir = 1'b0;
        if (item.finite_mass) begin
          f.fx = 32'(qmul(gx, longint'(item.mass)));
          f.fy = 32'(qmul(gy, longint'(item.mass)));
          f.fz = 32'(qmul(gz, longint'(item.mass)));
        end else begin
          f.applied = 1'b0;
        end
      end
      pfg_pkg::MODE_DRAG: begin
        d[0] = item.vel_x;
        d[1] = item.vel_y;
        d[2] = item.vel_z;
        len = norm3(d);
        ls = (len > 64'd2147483647) ? 64'sd2147483647 : longint'(len);
        m = -clip(qmul(k1, ls) + qmul(k2, qmul(ls, ls)));
      end
      pfg_pkg::MODE_SPRING: begin
        len = norm3(d);
        ls = (len > 64'd2147483647) ? 64'sd2147483647 : longint'(len);
        ls = (ls > rest) ? ls - rest : rest - ls;
        m = -qmul(k, clip(ls));
      end
      pfg_pkg::MODE_ANCHORED: begin
        len = norm3(d);
        ls = (len > 64'd2147483647) ? 64'sd2147483647 : longint'(len);
        m = qmul(clip(rest - ls), k);
      end
      pfg_pkg::MODE_BUNGEE: begin
        len = norm3(d);
        if (len <= longint'(rest)) begin
          f.applied = 1'b0;
          use_dir = 1'b0;
        end else begin
          ls = (len > 64'd2147483647) ? 64'sd2147483647 : longint'(len);
          m = qmul(k, clip(rest - ls));
        end
      end
      default: begin
        f.applied = 1'b0;
        use_dir = 1'b0;
      end
    endcase
    if (use_dir) begin
      len = norm3(d);
      for (int i = 0; i < 3; i++)
        v[i] = (len == 0) ? 0 : clip((m * d[i]) / longint'(len));
      f.fx = 32'(v[0]);
      f.fy = 32'(v[1]);
      f.fz = 32'(v[2]);
    end
    return f;
  endfunction

  assign forces_due = force_q.size();

  always @(posedge clk) begin
    force_t want;
    if (rst) begin
      mode <= pfg_pkg::MODE_GRAVITY;
      {k, rest, k1, k2, gx, gy, gz} <= '0;
      errors = 0;
      forces_seen = 0;
      force_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pfg_pkg::REG_FORCE_MODE:      mode <= cfg_data[2:0];
          pfg_pkg::REG_SPRING_CONSTANT: k    <= longint'($signed(cfg_data));
          pfg_pkg::REG_REST_LENGTH:     rest <= longint'({1'b0, cfg_data[30:0]});
          pfg_pkg::REG_DRAG_LINEAR:     k1   <= longint'($signed(cfg_data));
          pfg_pkg::REG_DRAG_QUADRATIC:  k2   <= longint'($signed(cfg_data));
          pfg_pkg::REG_GRAVITY_X:       gx   <= longint'($signed(cfg_data));
          pfg_pkg::REG_GRAVITY_Y:       gy   <= longint'($signed(cfg_data));
          pfg_pkg::REG_GRAVITY_Z:       gz   <= longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (item.valid && item.ready) force_q.insert(force_q.size(), particle_force());
      if (result.valid && result.ready) begin
        forces_seen++;
        if (force_q.size() == 0) begin
          $error("force transfer with nothing expected");
          errors++;
        end else begin
          want = force_q.pop_front();
          if (result.force_x !== want.fx) begin
            $error("force_x expected %0d actual %0d", want.fx, result.force_x);
            errors++;
          end
          if (result.force_y !== want.fy) begin
            $error("force_y expected %0d actual %0d", want.fy, result.force_y);
            errors++;
          end
          if (result.force_z !== want.fz) begin
            $error("force_z expected %0d actual %0d", want.fz, result.force_z);
            errors++;
          end
          if (result.applied !== want.applied) begin
            $error("applied expected %0b actual %0b", want.applied, result.applied);
            errors++;
          end
        end
      end
    end
  end

endmodule

/* dv/particle_force_generator_unit_tb.sv */
// Stimulus and verdict for particle_force_generator_unit: directed extremes per
// mode, then random register settings and particles with random stalls.
// Depends on pfg_pkg, pfg_if, particle_force_generator_unit and particle_force_generator_checker.
`timescale 1ns / 1ps

module particle_force_generator_unit_tb;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        quiet;
  int          errors, forces_due, forces_seen, particles_sent;

  pfg_item_if   item();
  pfg_result_if result();

  particle_force_generator_unit i_dut (
    .clk(clk), .rst(rst), .item(item.sink), .result(result.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  particle_force_generator_checker i_checker (
    .clk(clk), .rst(rst), .item(item), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .forces_due(forces_due), .forces_seen(forces_seen)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    #5_000_000;
    $display("FAIL particle_force_generator_unit");
    $finish;
  end

  // stall the result side in bursts
  initial begin
    int hold;
    result.ready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        result.ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 16);
        result.ready = 1'b0;
      end else begin
        result.ready = 1'b1;
      end
    end
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 6))
      0: return 32'h0;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      4: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
      5: return $urandom_range(0, 64) - 32;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    item.valid = 1'b0;
    wait (forces_due == 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic configure(logic [2:0] mode, logic [31:0] kk, logic [30:0] rl,
                           logic [31:0] a, logic [31:0] b, logic [31:0] g0,
                           logic [31:0] g1, logic [31:0] g2);
    drain();
    write_reg(pfg_pkg::REG_FORCE_MODE, {29'd0, mode});
    write_reg(pfg_pkg::REG_SPRING_CONSTANT, kk);
    write_reg(pfg_pkg::REG_REST_LENGTH, {1'b0, rl});
    write_reg(pfg_pkg::REG_DRAG_LINEAR, a);
    write_reg(pfg_pkg::REG_DRAG_QUADRATIC, b);
    write_reg(pfg_pkg::REG_GRAVITY_X, g0);
    write_reg(pfg_pkg::REG_GRAVITY_Y, g1);
    write_reg(pfg_pkg::REG_GRAVITY_Z, g2);
  endtask

  task automatic send(logic [31:0] p[3], logic [31:0] r[3], logic [31:0] v[3],
                      logic [30:0] m, logic fin);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      item.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item.valid = 1'b1;
    {item.pos_x, item.pos_y, item.pos_z} = {p[0], p[1], p[2]};
    {item.ref_x, item.ref_y, item.ref_z} = {r[0], r[1], r[2]};
    {item.vel_x, item.vel_y, item.vel_z} = {v[0], v[1], v[2]};
    item.mass = m;
    item.finite_mass = fin;
    do @(posedge clk); while (!item.ready);
    particles_sent++;
  endtask

  task automatic send_random(logic [30:0] rl);
    logic [31:0] p[3], r[3], v[3];
    logic [30:0] m;
    for (int i = 0; i < 3; i++) begin
      p[i] = pick32();
      v[i] = pick32();
      case ($urandom_range(0, 3))
        0: r[i] = pick32();
        1: r[i] = p[i];
        default: r[i] = p[i] + ((rl >> 1) & 32'h3FFF_FFFF) - $urandom_range(0, rl >> 1)
                        + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      endcase
    end
    case ($urandom_range(0, 3))
      0: m = 31'h7FFF_FFFF;
      1: m = 31'h0;
      2: m = 31'($urandom_range(0, 32'h0010_0000));
      default: m = 31'($urandom);
    endcase
    send(p, r, v, m, $urandom_range(0, 3) != 0);
  endtask

  initial begin
    logic [31:0] zr[3], hi[3], lo[3];
    logic [30:0] rl;
    rst = 1'b1;
    quiet = 1'b0;
    cfg_we = 1'b0;
    cfg_index = pfg_pkg::REG_FORCE_MODE;
    cfg_data = '0;
    particles_sent = 0;
    item.valid = 1'b0;
    {item.pos_x, item.pos_y, item.pos_z} = '0;
    {item.ref_x, item.ref_y, item.ref_z} = '0;
    {item.vel_x, item.vel_y, item.vel_z} = '0;
    item.mass = '0;
    item.finite_mass = 1'b0;
    zr = '{32'h0, 32'h0, 32'h0};
    hi = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    lo = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // each mode: zero vector, saturated offset, infinite mass
    for (int md = 0; md < 8; md++) begin
      configure(md[2:0], (md % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF,
                (md % 3 == 0) ? 31'h7FFF_FFFF : 31'h0,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h0001_0000);
      send(zr, zr, zr, 31'h7FFF_FFFF, 1'b1);
      send(hi, lo, lo, 31'h0001_0000, 1'b1);
      send(lo, hi, hi, 31'h7FFF_FFFF, 1'b0);
    end

    for (int ph = 0; ph < 16; ph++) begin
      quiet = (ph >= 13);
      case ($urandom_range(0, 3))
        0: rl = 31'h0;
        1: rl = 31'h7FFF_FFFF;
        default: rl = 31'($urandom_range(0, 32'h0080_0000));
      endcase
      configure((ph < 8) ? ph[2:0] : 3'($urandom_range(0, 4)), pick32(), rl,
                pick32(), pick32(), pick32(), pick32(), pick32());
      repeat (70) send_random(rl);
    end
    @(negedge clk);
    item.valid = 1'b0;
    drain();

    $display("Sent %0d particles over all eight mode codes, %0d forces checked.",
             particles_sent, forces_seen);
    if (errors == 0) begin
      $display("PASS particle_force_generator_unit");
    end else begin
      $display("FAIL particle_force_generator_unit");
    end
    $finish;
  end

endmodule

/* particle_force_generator_unit.f */
hw/rtl/pfg_pkg.sv
hw/rtl/pfg_if.sv
hw/rtl/pfg_isqrt.sv
hw/rtl/pfg_div.sv
hw/rtl/particle_force_generator_unit.sv
dv/particle_force_generator_checker.sv
dv/particle_force_generator_unit_tb.sv
